[hw/rtl/mwo_pkg.sv]
// Shared types and constants for the multi-waveform oscillator.
package mwo_pkg;

  localparam int unsigned MUL_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMP_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RING_EN    = 3'd6;

  localparam logic [2:0] WAVE_SINE    = 3'd1;
  localparam logic [2:0] WAVE_TRI     = 3'd2;
  localparam logic [2:0] WAVE_PULSE   = 3'd3;
  localparam logic [2:0] WAVE_NOISE   = 3'd4;
  localparam logic [2:0] WAVE_IMPULSE = 3'd5;

  localparam logic [2:0]  RST_WAVEFORM   = 3'd0;
  localparam logic [31:0] RST_PHASE_STEP = 32'd42852281;
  localparam logic [15:0] RST_WIDTH      = 16'd32768;
  localparam logic [31:0] RST_RISE_GAIN  = 32'd262144;
  localparam logic [31:0] RST_FALL_GAIN  = 32'd262144;
  localparam logic [15:0] RST_IMP_PERIOD = 16'd100;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [2*MUL_W-1:0] prod;
  } mul_rsp_t;

endpackage

[hw/rtl/multi_waveform_oscillator_top.sv]
// Top level of the multi-waveform oscillator with ring modulation.
//
//  channel | signals                                   | dir
//  in      | in_valid_i in_ready_o in_sample_i         | in
//  out     | out_valid_o out_ready_i out_sample_o stopped_o | out
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in
//
// One beat at a time: pulse, noise and impulse go via the post and out states,
// a stop straight to out, sine via sin1 and sin2 (index multiply and table read),
// triangle waits in tri (32-step serial gain multiply). Ring modulation adds a ring
// state for a second pass through the serial multiplier. The output register lets
// the next beat enter while a result waits. Reset sets registers to their defaults,
// phase and count to zero, the noise LFSR to its seed. The cfg port is always ready.
module multi_waveform_oscillator_top import mwo_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  output logic                         stopped_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned FB     = SAMPLE_BITS - 2;
  localparam int unsigned D      = SINE_TABLE_DEPTH;
  localparam int unsigned IDX_W  = $clog2(4 * D);
  localparam int unsigned IDX_PW = IDX_W + 32;
  localparam int unsigned ROM_AW = $clog2(D + 1);
  localparam logic [IDX_PW-1:0] IDX_MUL = IDX_PW'(4 * D);
  localparam logic [IDX_W-1:0]  Q1 = IDX_W'(D);
  localparam logic [IDX_W-1:0]  Q2 = IDX_W'(2 * D);
  localparam logic [IDX_W-1:0]  Q3 = IDX_W'(3 * D);
  localparam logic [SB-1:0] ONE_V = SB'(1) << FB;
  localparam logic [SB-1:0] MAX_V = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] MIN_V = {1'b1, {(SB-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SIN1 = 3'd1;
  localparam logic [2:0] ST_SIN2 = 3'd2;
  localparam logic [2:0] ST_TRI  = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;
  localparam logic [2:0] ST_RING = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  // configuration
  logic [2:0]  waveform_q;
  logic [31:0] phase_step_q, rise_gain_q, fall_gain_q;
  logic [15:0] width_q, period_q;
  logic        ring_q;

  // state
  logic [2:0]  state_q, state_d;
  logic [31:0] phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d, lfsr_q, lfsr_d;
  logic        res_stop_q, res_stop_d;
  logic        out_valid_q, out_valid_d;

  // payload
  logic [SB-1:0]    in_q, in_d, v_q, v_d, res_q, res_d, out_sample_q;
  logic             out_stop_q;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic             acc, out_load, wave_ok, tri_rise;
  logic [IDX_PW-1:0] sin_prod;
  logic [IDX_W-1:0]  off;
  logic [1:0]        quad;
  logic [ROM_AW-1:0] rom_addr;
  logic [FB:0]       rom_data;
  logic [SB-1:0]     sin_v, noise_v, tri_v, ring_v, abs_v, abs_in;
  logic [SB+15:0]    nz_wide;
  logic [15:0]       lfsr_nx, cnt_inc, per;
  logic [SB+13:0]    tri_sh;
  logic [2*SB-1:0]   rprod, rs;
  logic [SB:0]       rsh;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;

  assign wave_ok = (waveform_q == WAVE_SINE) || (waveform_q == WAVE_TRI) ||
                   (waveform_q == WAVE_PULSE) || (waveform_q == WAVE_NOISE) ||
                   (waveform_q == WAVE_IMPULSE);

  // sine addressing
  assign sin_prod = IDX_PW'(phase_q) * IDX_MUL;

  always_comb begin
    priority if (idx_q >= Q3) begin
      quad = 2'd3;
      off  = idx_q - Q3;
    end else if (idx_q >= Q2) begin
      quad = 2'd2;
      off  = idx_q - Q2;
    end else if (idx_q >= Q1) begin
      quad = 2'd1;
      off  = idx_q - Q1;
    end else begin
      quad = 2'd0;
      off  = idx_q;
    end
  end

  assign rom_addr = quad[0] ? (ROM_AW'(D) - ROM_AW'(off)) : ROM_AW'(off);
  assign sin_v    = quad[1] ? (SB'(0) - SB'(rom_data)) : SB'(rom_data);

  mwo_sine_rom #(
    .DEPTH (D),
    .FB    (FB)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // triangle and pulse split
  assign tri_rise = (phase_q <= {width_q, 16'h0000});
  assign tri_sh   = mul_rsp.prod[63:50-SB];
  assign tri_v    = (|tri_sh[SB+13:SB-1]) ? MAX_V : tri_sh[SB-1:0];

  // noise
  assign lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : 16'h0000);
  assign nz_wide = {SB'(0), lfsr_nx} << FB;
  assign noise_v = nz_wide[SB+15:16];

  // impulse counter
  assign per     = (period_q == 16'd0) ? 16'd1 : period_q;
  assign cnt_inc = cnt_q + 16'd1;

  // ring modulation
  assign abs_v  = v_q[SB-1] ? (SB'(0) - v_q) : v_q;
  assign abs_in = in_q[SB-1] ? (SB'(0) - in_q) : in_q;
  assign rprod  = mul_rsp.prod[2*SB-1:0];
  assign rs     = (v_q[SB-1] ^ in_q[SB-1]) ? ((2*SB)'(0) - rprod) : rprod;
  assign rsh    = rs[2*SB-1:SB-1];
  assign ring_v = (rsh[SB] != rsh[SB-1]) ? (rsh[SB] ? MIN_V : MAX_V) : rsh[SB-1:0];

  always_comb begin
    mul_req.start = (acc && waveform_q == WAVE_TRI) || (state_q == ST_POST && ring_q);
    if (state_q == ST_POST) begin
      mul_req.a = MUL_W'(abs_v);
      mul_req.b = MUL_W'(abs_in);
    end else begin
      mul_req.a = tri_rise ? rise_gain_q : fall_gain_q;
      mul_req.b = tri_rise ? phase_q : (32'd0 - phase_q);
    end
  end

  mwo_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    lfsr_d     = lfsr_q;
    res_stop_d = res_stop_q;
    in_d       = in_q;
    v_d        = v_q;
    res_d      = res_q;
    idx_d      = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          in_d       = in_sample_i;
          idx_d      = sin_prod[IDX_PW-1:32];
          res_stop_d = !wave_ok;
          if (wave_ok) begin
            phase_d = phase_q + phase_step_q;
            cnt_d   = (cnt_inc >= per) ? 16'd0 : cnt_inc;
          end
          unique case (waveform_q)
            WAVE_SINE: state_d = ST_SIN1;
            WAVE_TRI:  state_d = ST_TRI;
            WAVE_PULSE: begin
              v_d     = tri_rise ? ONE_V : (SB'(0) - ONE_V);
              state_d = ST_POST;
            end
            WAVE_NOISE: begin
              lfsr_d  = lfsr_nx;
              v_d     = noise_v;
              state_d = ST_POST;
            end
            WAVE_IMPULSE: begin
              v_d     = (cnt_q == 16'd0) ? ONE_V : '0;
              state_d = ST_POST;
            end
            default: begin
              res_d   = '0;
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_SIN1: state_d = ST_SIN2;
      ST_SIN2: begin
        v_d     = sin_v;
        state_d = ST_POST;
      end
      ST_TRI: begin
        if (mul_rsp.done) begin
          v_d     = tri_v;
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        if (ring_q) begin
          state_d = ST_RING;
        end else begin
          res_d   = v_q;
          state_d = ST_OUT;
        end
      end
      ST_RING: begin
        if (mul_rsp.done) begin
          res_d   = ring_v;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q   <= RST_WAVEFORM;
      phase_step_q <= RST_PHASE_STEP;
      width_q      <= RST_WIDTH;
      rise_gain_q  <= RST_RISE_GAIN;
      fall_gain_q  <= RST_FALL_GAIN;
      period_q     <= RST_IMP_PERIOD;
      ring_q       <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WAVEFORM:   waveform_q   <= cfg_data_i[2:0];
        REG_PHASE_STEP: phase_step_q <= cfg_data_i;
        REG_WIDTH:      width_q      <= cfg_data_i[15:0];
        REG_RISE_GAIN:  rise_gain_q  <= cfg_data_i;
        REG_FALL_GAIN:  fall_gain_q  <= cfg_data_i;
        REG_IMP_PERIOD: period_q     <= cfg_data_i[15:0];
        REG_RING_EN:    ring_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      cnt_q       <= '0;
      lfsr_q      <= LFSR_SEED;
      res_stop_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      lfsr_q      <= lfsr_d;
      res_stop_q  <= res_stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    v_q   <= v_d;
    res_q <= res_d;
    idx_q <= idx_d;
    if (out_load) begin
      out_sample_q <= res_q;
      out_stop_q   <= res_stop_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign stopped_o    = out_stop_q;

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(phase_q)) else $error("phase moved without an input beat");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stopped_o) |-> (out_sample_o == '0))
    else $error("stopped beat carries a nonzero sample");

  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.busy |-> (state_q == ST_TRI || state_q == ST_RING))
    else $error("multiplier busy outside a multiply state");

endmodule

[hw/rtl/mwo_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module mwo_serial_mul import mwo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(MUL_W + 1);

  logic [MUL_W-1:0] a_q, hi_q, lo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [MUL_W:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        cnt_q <= CNT_W'(MUL_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= req_i.a;
      hi_q <= '0;
      lo_q <= req_i.b;
    end else if (cnt_q != '0) begin
      hi_q <= sum[MUL_W:1];
      lo_q <= {sum[0], lo_q[MUL_W-1:1]};
    end
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q, lo_q};

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !rsp_o.busy) else $error("multiplier restarted while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> !rsp_o.busy) else $error("done raised while still stepping");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.busy && !req_i.start) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("step counter skipped");

endmodule

[hw/rtl/mwo_sine_rom.sv]
// Quarter-wave sine table with registered read.
module mwo_sine_rom import mwo_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned FB    = 14
) (
  input  logic                         clk_i,
  input  logic [$clog2(DEPTH+1)-1:0]   addr_i,
  output logic [FB:0]                  data_o
);

  logic [FB:0] tab [DEPTH+1];
  logic [FB:0] data_q;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    localparam logic [63:0] X   = (HALF_PI_Q30 * k) / DEPTH;
    localparam logic [63:0] X2  = (X * X) >> 30;
    localparam logic [63:0] T1  = ((X  * X2) >> 30) / 6;
    localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 20;
    localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 42;
    localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 72;
    localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 110;
    localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 156;
    localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 210;
    localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
    localparam logic [63:0] ENT = (SUM + (64'd1 << (29 - FB))) >> (30 - FB);
    assign tab[k] = ENT[FB:0];
  end

  always_ff @(posedge clk_i) begin
    data_q <= tab[addr_i];
  end

  assign data_o = data_q;

endmodule
